FILE: design/lphi_pkg.sv
// ----------------------------------------------------------------------------
// lphi_pkg
// Shared widths, codes and types for the linear probing hash insert core.
// ----------------------------------------------------------------------------
`default_nettype none

package lphi_pkg;

  localparam int KEY_W  = 31;
  localparam int POS_W  = 7;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 8;

  // action codes of an input word
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // status codes of a result word
  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_READ     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_CLEARED  = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_READ,
    S_DONE
  } lphi_state_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [KEY_W-1:0]  slot_key;
    logic              slot_occupied;
  } lphi_res_t;

endpackage

`default_nettype wire

FILE: design/lphi_if.sv
// ----------------------------------------------------------------------------
// lphi_if
// Valid/ready channels carrying input and result words of the hash core.
// ----------------------------------------------------------------------------
`default_nettype none

interface lphi_in_if import lphi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [KEY_W-1:0] key;
  logic [POS_W-1:0] slot;

  modport source (output valid, output action, output key, output slot, input ready);
  modport sink   (input valid, input action, input key, input slot, output ready);
endinterface

interface lphi_out_if import lphi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  position;
  logic [KEY_W-1:0]  slot_key;
  logic              slot_occupied;

  modport source (output valid, output status, output position, output slot_key,
                  output slot_occupied, input ready);
  modport sink   (input valid, input status, input position, input slot_key,
                  input slot_occupied, output ready);
endinterface

`default_nettype wire

FILE: design/linear_probe_hash_insert_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_insert_core
// Open addressing hash table with linear probing, held in one slot memory.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        action, key, slot
//  out_ch    out  valid/ready        status, position, slot_key, slot_occupied
//  cfg_*     in   write enable only  table_size (cfg_wdata)
//
//  Insert: accept, remainder of the key modulo table_size in lphi_mod, then
//  one slot read per cycle through the memory's single read port, up to
//  table_size reads. Read: the slot is read at accept, the result built in
//  S_READ. Clear: one slot written per cycle over all TABLE_DEPTH slots.
//  After reset the same sweep runs (no result word); in_ch.ready stays low
//  until it ends. Config writes are taken any time.
//  A result waits in the output register; out_ch stalls hold the core in
//  its finishing state, one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_insert_core import lphi_pkg::*; #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  lphi_in_if.sink          in_ch,
  lphi_out_if.source       out_ch
);

  localparam int IW = $clog2(TABLE_DEPTH);       // slot address
  localparam int NW = $clog2(TABLE_DEPTH + 1);   // slot count
  localparam int MW = KEY_W + 1;                 // {valid, key}
  localparam logic [NW-1:0] SIZE_RST = NW'((TABLE_DEPTH < 128) ? TABLE_DEPTH : 128);

  // slot memory: bit KEY_W is the occupied flag
  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] mem_q_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;

  lphi_state_t   state_r, state_nxt;
  logic [NW-1:0] size_r, size_nxt;
  logic [IW-1:0] clr_idx_r, clr_idx_nxt;
  logic          clr_report_r, clr_report_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [NW-1:0] issued_r, issued_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [POS_W-1:0] slot_r, slot_nxt;
  logic          in_range_r, in_range_nxt;
  lphi_res_t     res_r, res_nxt;
  lphi_res_t     out_data_r;
  logic          out_valid_r, out_valid_nxt;
  logic          out_load;

  logic          mod_start;
  logic          mod_done;
  logic [NW-1:0] mod_rem;

  lphi_mod #(.NW(NW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_ch.key),
    .divisor  (size_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // clamp the written size into 1..TABLE_DEPTH
  always_comb begin
    if (cfg_wdata == '0) begin
      size_nxt = NW'(1);
    end else if (32'(cfg_wdata) > TABLE_DEPTH) begin
      size_nxt = NW'(TABLE_DEPTH);
    end else begin
      size_nxt = NW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      size_r       <= SIZE_RST;
      clr_idx_r    <= '0;
      clr_report_r <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      clr_report_r <= clr_report_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        size_r <= size_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    issued_r   <= issued_nxt;
    chk_idx_r  <= chk_idx_nxt;
    key_r      <= key_nxt;
    slot_r     <= slot_nxt;
    in_range_r <= in_range_nxt;
    res_r      <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    clr_report_nxt = clr_report_r;
    rd_idx_nxt     = rd_idx_r;
    issued_nxt     = issued_r;
    pend_nxt       = pend_r;
    chk_idx_nxt    = chk_idx_r;
    key_nxt        = key_r;
    slot_nxt       = slot_r;
    in_range_nxt   = in_range_r;
    res_nxt        = res_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_idx_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = rd_idx_r;
    mod_start      = 1'b0;
    in_ch.ready    = 1'b0;
    out_load       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        // sweep: empty one slot per cycle
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + IW'(1);
        if (clr_idx_r == IW'(TABLE_DEPTH - 1)) begin
          clr_idx_nxt    = '0;
          clr_report_nxt = 1'b0;
          if (clr_report_r) begin
            res_nxt   = '{status: STAT_CLEARED, position: '0, slot_key: '0,
                          slot_occupied: 1'b0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          key_nxt  = in_ch.key;
          slot_nxt = in_ch.slot;
          case (in_ch.action)
            ACT_INSERT: begin
              mod_start = 1'b1;
              state_nxt = S_MOD;
            end
            ACT_READ: begin
              mem_re       = 1'b1;
              mem_raddr    = IW'(in_ch.slot);
              in_range_nxt = 32'(in_ch.slot) < 32'(size_r);
              state_nxt    = S_READ;
            end
            ACT_CLEAR: begin
              clr_report_nxt = 1'b1;
              state_nxt      = S_CLEAR;
            end
            default: begin
              // unused action: drop the word, no result
            end
          endcase
        end
      end

      S_MOD: begin
        if (mod_done) begin
          rd_idx_nxt = IW'(mod_rem);
          issued_nxt = '0;
          pend_nxt   = 1'b0;
          state_nxt  = S_PROBE;
        end
      end

      S_PROBE: begin
        // one read issued per cycle; the slot read last cycle is checked now
        if (pend_r && !mem_q_r[KEY_W]) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx_r;
          mem_wdata = {1'b1, key_r};
          res_nxt   = '{status: STAT_INSERTED, position: POS_W'(chk_idx_r),
                        slot_key: key_r, slot_occupied: 1'b1};
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (issued_r == size_r) begin
          // every slot in use checked and taken
          res_nxt   = '{status: STAT_FULL, position: '0, slot_key: '0,
                        slot_occupied: 1'b0};
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = rd_idx_r;
          chk_idx_nxt = rd_idx_r;
          pend_nxt    = 1'b1;
          issued_nxt  = issued_r + NW'(1);
          if ((NW'(rd_idx_r) + NW'(1)) == size_r) begin
            rd_idx_nxt = '0;
          end else begin
            rd_idx_nxt = rd_idx_r + IW'(1);
          end
        end
      end

      S_READ: begin
        res_nxt.status   = STAT_READ;
        res_nxt.position = slot_r;
        if (in_range_r && mem_q_r[KEY_W]) begin
          res_nxt.slot_key      = mem_q_r[KEY_W-1:0];
          res_nxt.slot_occupied = 1'b1;
        end else begin
          res_nxt.slot_key      = '0;
          res_nxt.slot_occupied = 1'b0;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_data_r.status;
  assign out_ch.position      = out_data_r.position;
  assign out_ch.slot_key      = out_data_r.slot_key;
  assign out_ch.slot_occupied = out_data_r.slot_occupied;

  // an insert never lands beyond the slots in use
  a_insert_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_PROBE) |-> (32'(mem_waddr) < 32'(size_r)))
    else $error("insert wrote a slot beyond the table size");

  // the probe never issues more reads than slots in use
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (issued_r <= size_r))
    else $error("probe count exceeded the table size");

  // the remainder unit finishes only while the core waits for it
  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_MOD))
    else $error("remainder done outside the hash state");

endmodule

`default_nettype wire

FILE: design/lphi_mod.sv
// ----------------------------------------------------------------------------
// lphi_mod
// Restoring remainder unit: key modulo table size, one key bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lphi_mod import lphi_pkg::*; #(
  parameter int NW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [NW-1:0]    divisor,
  output logic             done,
  output logic [NW-1:0]    rem
);

  localparam int CNT_W = $clog2(KEY_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    rem_r;
  logic [NW-1:0]    rem_nxt;
  logic [KEY_W-1:0] dvd_r;
  logic [NW-1:0]    div_r;
  logic [NW:0]      trial;

  // shift in the next key bit, subtract the divisor when it fits
  always_comb begin
    trial = {rem_r, dvd_r[KEY_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = NW'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(KEY_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[KEY_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire
